FILE: src/csm_pkg.sv
// Shared types, constants and tables for the centroid and scatter matrix block.
// No dependencies; every other file in src imports this package.
package csm_pkg;

    // Store capacity and coordinate format.
    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 20;
    localparam int NAXES      = 3;
    localparam int NPAIRS     = 6;

    // Derived widths.
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = COORD_W + ADDR_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int DEV_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * DEV_W;

    // Result field widths.
    localparam int SQ_W    = 51;
    localparam int CROSS_W = 52;
    localparam int ACC_W   = CROSS_W;
    localparam int PU_W    = 11;

    // Configuration port.
    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;
    localparam int DIM_W     = 2;
    localparam logic [REG_IDX_W-1:0] REG_DIMENSIONS = '0;
    localparam logic [DIM_W-1:0]     DIM_3D         = 2'd3;
    localparam logic [DIM_W-1:0]     DIM_RESET      = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [NAXES-1:0] point_t;

    typedef logic [1:0] axis_t;

    // Axis pairs of the scatter entries, in the order xx, xy, xz, yy, yz, zz.
    localparam axis_t PAIR_A [NPAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam axis_t PAIR_B [NPAIRS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // One result; the first field sits in the highest bits, centroid_x in the lowest.
    typedef struct packed {
        logic                 overflowed;
        logic [PU_W-1:0]      points_used;
        logic [SQ_W-1:0]      scatter_zz;
        logic [CROSS_W-1:0]   scatter_yz;
        logic [SQ_W-1:0]      scatter_yy;
        logic [CROSS_W-1:0]   scatter_xz;
        logic [CROSS_W-1:0]   scatter_xy;
        logic [SQ_W-1:0]      scatter_xx;
        coord_t               centroid_z;
        coord_t               centroid_y;
        coord_t               centroid_x;
    } result_t;

    localparam int S_TDATA_W = ((NAXES * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

    // Controller to datapath.
    typedef struct packed {
        logic pt_accept;
        logic div_start;
        logic rd_en;
        logic emit;
    } csm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
        logic rd_last;
        logic pipe_busy;
        logic out_free;
    } csm_stat_t;

endpackage

FILE: src/csm_div.sv
// Sequential signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on csm_pkg for the sum and count widths.
module csm_div
    import csm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  q_reg;
    logic              neg_reg;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_sub;
    logic              fits;

    // Restoring step: bring in the next dividend bit and try the subtract.
    always_comb begin
        rem_shift = {rem_reg, q_reg[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
        fits      = rem_shift >= {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(SUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_W-1];
            q_reg   <= dividend[SUM_W-1] ? -dividend : dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            q_reg   <= {q_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -q_reg : q_reg;

endmodule

FILE: src/csm_datapath.sv
// Datapath: point store, running sums, centroid dividers, deviation and
// product pipeline, scatter accumulators and the result register.
// Depends on csm_pkg and csm_div.
module csm_datapath
    import csm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  csm_cmd_t  cmd,
    input  logic      three_d,
    input  point_t    s_point,
    output csm_stat_t stat,
    output logic      m_tvalid,
    input  logic      m_tready,
    output result_t   result
);

    point_t                   mem [MAX_POINTS];

    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic signed [SUM_W-1:0]  sum_reg [NAXES];
    coord_t                   cen_reg [NAXES];
    logic [ADDR_W-1:0]        rd_addr_reg;

    point_t                   rd_data_reg;
    logic signed [DEV_W-1:0]  dev_reg [NAXES];
    logic signed [PROD_W-1:0] prod_reg [NPAIRS];
    logic signed [ACC_W-1:0]  acc_reg [NPAIRS];
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;

    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     not_full;
    logic                     wr_en;
    logic [NAXES-1:0]         div_done;
    logic signed [SUM_W-1:0]  quot [NAXES];
    coord_t                   s_coord [NAXES];
    coord_t                   rd_coord [NAXES];
    result_t                  res_next;

    always_comb begin
        for (int k = 0; k < NAXES; k++) begin
            s_coord[k]  = s_point[k];
            rd_coord[k] = rd_data_reg[k];
        end
    end

    assign not_full = count_reg != CNT_W'(MAX_POINTS);
    assign wr_en    = cmd.pt_accept && not_full;

    // Point store: one write port on accept, one registered read port for the pass.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= s_point;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    // Set bookkeeping: count, overflow mark and per-axis sums.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int k = 0; k < NAXES; k++) begin
                sum_reg[k] <= '0;
            end
        end else if (cmd.pt_accept) begin
            if (not_full) begin
                count_reg <= count_reg + CNT_W'(1);
                for (int k = 0; k < NAXES; k++) begin
                    sum_reg[k] <= sum_reg[k] + SUM_W'(s_coord[k]);
                end
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NAXES; k++) begin : g_div
        csm_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (cmd.div_start),
            .dividend (sum_reg[k]),
            .divisor  (count_reg),
            .done     (div_done[k]),
            .quotient (quot[k])
        );
    end

    // The mean always fits the coordinate format, so the low bits are exact.
    always_ff @(posedge aclk) begin
        if (&div_done) begin
            cen_reg[0] <= quot[0][COORD_W-1:0];
            cen_reg[1] <= quot[1][COORD_W-1:0];
            cen_reg[2] <= three_d ? quot[2][COORD_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rd_addr_reg <= '0;
        end else if (cmd.rd_en) begin
            rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
        end
    end

    // Pass pipeline: read, deviation, product, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NAXES; k++) begin
            if (k == NAXES - 1 && !three_d) begin
                dev_reg[k] <= '0;
            end else begin
                dev_reg[k] <= DEV_W'(rd_coord[k]) - DEV_W'(cen_reg[k]);
            end
        end
        for (int j = 0; j < NPAIRS; j++) begin
            prod_reg[j] <= dev_reg[PAIR_A[j]] * dev_reg[PAIR_B[j]];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NPAIRS; j++) begin
            if (cmd.div_start) begin
                acc_reg[j] <= '0;
            end else if (v3_reg) begin
                acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j]);
            end
        end
    end

    always_comb begin
        res_next.centroid_x  = cen_reg[0];
        res_next.centroid_y  = cen_reg[1];
        res_next.centroid_z  = cen_reg[2];
        res_next.scatter_xx  = acc_reg[0][SQ_W-1:0];
        res_next.scatter_xy  = acc_reg[1][CROSS_W-1:0];
        res_next.scatter_xz  = acc_reg[2][CROSS_W-1:0];
        res_next.scatter_yy  = acc_reg[3][SQ_W-1:0];
        res_next.scatter_yz  = acc_reg[4][CROSS_W-1:0];
        res_next.scatter_zz  = acc_reg[5][SQ_W-1:0];
        res_next.points_used = PU_W'(count_reg);
        res_next.overflowed  = ovf_reg;
    end

    // Result register; a new point set may load while the result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    always_comb begin
        stat.div_done  = &div_done;
        stat.rd_last   = (CNT_W'(rd_addr_reg) + CNT_W'(1)) == count_reg;
        stat.pipe_busy = v1_reg || v2_reg || v3_reg;
        stat.out_free  = !out_valid_reg || m_tready;
    end

    a_emit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result taken while products are still in flight");

    a_set_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (count_reg == '0 && !ovf_reg && out_valid_reg))
        else $error("point set not closed after a result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store capacity");

    a_read_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (CNT_W'(rd_addr_reg) < count_reg))
        else $error("pass reads a store entry outside the current set");

endmodule

FILE: src/csm_ctrl.sv
// Controller state machine: sequences loading, division, the pass and the result.
// Depends on csm_pkg for the command and status structs.
module csm_ctrl
    import csm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  csm_stat_t stat,
    output csm_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_DSTART = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_PASS   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.pt_accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                cmd.rd_en = 1'b1;
                if (stat.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: src/centroid_scatter_matrix.sv
// Centroid and scatter matrix of a 2D or 3D point set. Points load at one per cycle
// while the set loads. After the point marked last, input stalls while the block
// starts, runs bit-serial division for the centroid, makes N store reads (N points)
// for the deviation pass, drains a four-stage read/deviate/multiply/accumulate
// pipeline and hands the result on. Reset (aresetn, synchronous, low) empties the
// set and sets dimensions to 3; the point store itself is not cleared.
module centroid_scatter_matrix
    import csm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    // Point requests.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // coord_x, coord_y, coord_z, zero pad
    input  logic                 s_tlast,   // last_point

    // Result requests.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // centroid_x, centroid_y, centroid_z,
                                            // scatter_xx, scatter_xy, scatter_xz,
                                            // scatter_yy, scatter_yz, scatter_zz,
                                            // points_used, overflowed, zero pad
);

    logic [DIM_W-1:0] dim_reg;
    logic             three_d;
    logic             reg_hit;
    csm_cmd_t         cmd;
    csm_stat_t        stat;
    point_t           s_point;
    result_t          result;

    // The dimensions register. Any value below 3 selects 2D operation, where z is
    // ignored and every z-derived result field reads zero. The user must write it
    // only while no set is being computed (the block does not check), so a pass sees one mode.
    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1:2] == REG_DIMENSIONS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            dim_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign prdata  = reg_hit ? PDATA_W'(dim_reg) : '0;
    assign three_d = dim_reg == DIM_3D;

    // The point fields sit packed from the lowest bit, x first.
    assign s_point = s_tdata[NAXES*COORD_W-1:0];

    // The controller accepts points only while loading; once the last point of a
    // set is in, it runs the division and the pass and then hands the result to
    // the output register, which may still hold the previous set's result while
    // the next set loads.
    csm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .three_d  (three_d),
        .s_point  (s_point),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = M_TDATA_W'(result);

endmodule

FILE: sim/csm_checker.sv
// Result checker for the centroid and scatter matrix block: follows the register
// writes and point requests, predicts each result and compares it field by field.
// Depends on csm_pkg for the port widths, the result layout and the register codes.
module csm_checker
    import csm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_total,
    output int                   results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the block state.
    coord_t           stored_pts [MAX_POINTS][NAXES];
    int               stored_count;
    longint           axis_sum [NAXES];
    bit               points_dropped;
    logic [DIM_W-1:0] dim_mode;

    result_t          awaited_results [$];
    int               mismatch_count;

    function automatic void open_new_set();
        stored_count   = 0;
        points_dropped = 0;
        for (int k = 0; k < NAXES; k++) begin
            axis_sum[k] = 0;
        end
    endfunction

    // Centroid by truncating division, then the deviation pass over the set.
    function automatic result_t predict_scatter();
        result_t r;
        longint  cen [NAXES];
        longint  dev [NAXES];
        longint  acc [NPAIRS];
        bit      full3;
        full3 = (dim_mode == DIM_3D);
        for (int k = 0; k < NAXES; k++) begin
            cen[k] = axis_sum[k] / longint'(stored_count);
        end
        if (!full3) begin
            cen[2] = 0;
        end
        for (int p = 0; p < NPAIRS; p++) begin
            acc[p] = 0;
        end
        for (int i = 0; i < stored_count; i++) begin
            for (int k = 0; k < NAXES; k++) begin
                dev[k] = longint'(stored_pts[i][k]) - cen[k];
            end
            if (!full3) begin
                dev[2] = 0;
            end
            for (int p = 0; p < NPAIRS; p++) begin
                acc[p] += dev[PAIR_A[p]] * dev[PAIR_B[p]];
            end
        end
        r.centroid_x  = coord_t'(cen[0]);
        r.centroid_y  = coord_t'(cen[1]);
        r.centroid_z  = coord_t'(cen[2]);
        r.scatter_xx  = SQ_W'(acc[0]);
        r.scatter_xy  = CROSS_W'(acc[1]);
        r.scatter_xz  = CROSS_W'(acc[2]);
        r.scatter_yy  = SQ_W'(acc[3]);
        r.scatter_yz  = CROSS_W'(acc[4]);
        r.scatter_zz  = SQ_W'(acc[5]);
        r.points_used = PU_W'(stored_count);
        r.overflowed  = points_dropped;
        return r;
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        coord_t  pt [NAXES];
        if (!aresetn) begin
            dim_mode = DIM_RESET;
            open_new_set();
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[PADDR_W-1:2] == REG_DIMENSIONS) begin
                dim_mode = pwdata[DIM_W-1:0];
            end

            if (s_tvalid && s_tready) begin
                for (int k = 0; k < NAXES; k++) begin
                    pt[k] = coord_t'(s_tdata[k*COORD_W +: COORD_W]);
                end
                if (stored_count < MAX_POINTS) begin
                    for (int k = 0; k < NAXES; k++) begin
                        stored_pts[stored_count][k] = pt[k];
                        axis_sum[k] += longint'(pt[k]);
                    end
                    stored_count++;
                end else begin
                    points_dropped = 1;
                end
                if (s_tlast) begin
                    awaited_results.push_back(predict_scatter());
                    open_new_set();
                end
            end

            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result request with no result awaited");
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    seen = m_tdata[$bits(result_t)-1:0];
                    compare_field("centroid_x", 64'(want.centroid_x), 64'(seen.centroid_x));
                    compare_field("centroid_y", 64'(want.centroid_y), 64'(seen.centroid_y));
                    compare_field("centroid_z", 64'(want.centroid_z), 64'(seen.centroid_z));
                    compare_field("scatter_xx", 64'(want.scatter_xx), 64'(seen.scatter_xx));
                    compare_field("scatter_xy", 64'(want.scatter_xy), 64'(seen.scatter_xy));
                    compare_field("scatter_xz", 64'(want.scatter_xz), 64'(seen.scatter_xz));
                    compare_field("scatter_yy", 64'(want.scatter_yy), 64'(seen.scatter_yy));
                    compare_field("scatter_yz", 64'(want.scatter_yz), 64'(seen.scatter_yz));
                    compare_field("scatter_zz", 64'(want.scatter_zz), 64'(seen.scatter_zz));
                    compare_field("points_used", 64'(want.points_used),
                                  64'(seen.points_used));
                    compare_field("overflowed", 64'(want.overflowed), 64'(seen.overflowed));
                end
            end
        end
        results_outstanding <= awaited_results.size();
        mismatch_total      <= mismatch_count;
    end

endmodule

FILE: sim/testbench.sv
// Top level of the simulation: clock, reset, register writes and point requests
// for centroid_scatter_matrix, plus the verdict. Depends on csm_pkg, the block
// itself and csm_checker, which predicts and compares the result requests.
module testbench;
    import csm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Stretch of quiet cycles after which the run is declared hung. The slowest
    // legal gap is the longest random set's division, pass and drain, possibly
    // stacked behind the long receiver hold-off, with margin on top.
    localparam int WATCHDOG_LIMIT = 6000;
    // Cycles the receiver refuses results once the squeeze is armed.
    localparam int HOLD_LEN       = 700;
    // Cycle window in which neither side idles.
    localparam int CALM_START     = 3000;
    localparam int CALM_END       = 4500;
    // Pause before a register write once all results are in, and at the end.
    localparam int SETTLE_CYCLES  = 48;
    localparam int DRAIN_CYCLES   = 64;
    // Point requests after which the random phases stop.
    localparam int RANDOM_TARGET  = 840;

    localparam coord_t C_MAX = coord_t'(2 ** (COORD_W - 1) - 1);
    localparam coord_t C_MIN = coord_t'(-(2 ** (COORD_W - 1)));

    // Coordinate styles of a random set.
    typedef enum int {STYLE_UNIFORM, STYLE_CLUSTER, STYLE_EXTREME} point_style_e;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // coord_x, coord_y, coord_z, zero pad
    logic                 s_tlast  = 1'b0; // last_point
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // centroid_x, centroid_y, centroid_z,
                                           // scatter_xx, scatter_xy, scatter_xz,
                                           // scatter_yy, scatter_yz, scatter_zz,
                                           // points_used, overflowed, zero pad

    int   fail_count;
    int   results_outstanding;
    int   cycle_count   = 0;
    int   points_sent   = 0;
    logic squeeze_armed = 1'b0;
    int   squeeze_left  = HOLD_LEN;

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    centroid_scatter_matrix DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    csm_checker scatter_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tlast             (s_tlast),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_total      (fail_count),
        .results_outstanding (results_outstanding)
    );

    // Both sides idle in roughly a quarter of the cycles, except inside the
    // calm window, where requests flow back to back whenever the block allows.
    function automatic bit take_break();
        if (cycle_count >= CALM_START && cycle_count < CALM_END) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 26;
    endfunction

    // Receiver. Once the random part arms the squeeze, it refuses results until the
    // HOLD_LEN countdown runs out while points keep coming, so the finished result sits in
    // the block, the next set completes behind it and the input has to stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (squeeze_armed && squeeze_left > 0) begin
            m_tready     <= 1'b0;
            squeeze_left <= squeeze_left - 1;
        end else begin
            m_tready <= !take_break();
        end
    end

    // Watchdog: ends the run once the quiet stretch, with no request accepted on
    // either channel, reaches WATCHDOG_LIMIT.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Offers one point request, with random idle cycles in front of it, and
    // returns at the edge where it is accepted. Valid stays high into the next
    // call unless that call starts with an idle cycle.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input bit last);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - NAXES * COORD_W){1'b0}}, z, y, x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        points_sent++;
    endtask

    // Waits until every predicted result has come out, then lets the block run
    // dry before a register write. The first edge lets the checker catch up
    // with a point accepted at the current edge.
    task automatic settle();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (results_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready. The upper
    // data bits carry noise that the register must ignore.
    task automatic write_dimensions(input logic [DIM_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DIMENSIONS, 2'b00};
        pwdata  <= {PDATA_W'($urandom()) >> DIM_W << DIM_W} | PDATA_W'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic coord_t pick_coord(input point_style_e style, input coord_t center,
                                          input int spread);
        case (style)
            STYLE_CLUSTER: begin
                return coord_t'(int'(center) + $urandom_range(0, 2 * spread) - spread);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
            default: begin
                return coord_t'($urandom());
            end
        endcase
    endfunction

    // Mostly small sets, some medium, a few long ones.
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 24);
        end else if (r < 97) begin
            return $urandom_range(25, 120);
        end
        return $urandom_range(150, 300);
    endfunction

    // One complete set: size points, the last one marked.
    task automatic run_random_set(input int size, input point_style_e style);
        coord_t cx;
        coord_t cy;
        coord_t cz;
        int     spread;
        cx     = coord_t'($urandom());
        cy     = coord_t'($urandom());
        cz     = coord_t'($urandom());
        spread = 1 << $urandom_range(0, 12);
        for (int i = 0; i < size; i++) begin
            send_point(pick_coord(style, cx, spread), pick_coord(style, cy, spread),
                       pick_coord(style, cz, spread), i == size - 1);
        end
    endtask

    function automatic logic [DIM_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return DIM_3D;
        end else if (r < 8) begin
            return 2'd2;
        end else if (r < 9) begin
            return 2'd0;
        end
        return 2'd1;
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets, first in the 3D mode that reset leaves in force.
        // A single point at the top of the range is its own centroid.
        send_point(C_MAX, C_MAX, C_MAX, 1'b1);
        // Both extremes: the sums come to -1, and truncation toward zero gives 0
        // with the widest deviations the format allows.
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, C_MAX, 1'b1);
        // Odd negative sums must round toward zero, not down.
        send_point(coord_t'(-3), coord_t'(5), coord_t'(-7), 1'b0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        // All points at the bottom of the range: no spread at all.
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_MIN, C_MIN, C_MIN, 1'b1);

        // 2D mode: z carries extremes that must not show anywhere.
        settle();
        write_dimensions(2'd2);
        send_point(coord_t'(100), coord_t'(-200), coord_t'(9999), 1'b0);
        send_point(coord_t'(-300), coord_t'(50), C_MIN, 1'b0);
        send_point(coord_t'(7), coord_t'(7), C_MAX, 1'b1);

        // The other codes below 3 behave as 2D mode too.
        settle();
        write_dimensions(2'd0);
        send_point(C_MAX, C_MIN, C_MAX, 1'b0);
        send_point(coord_t'(-1), coord_t'(1), coord_t'(-1), 1'b1);
        settle();
        write_dimensions(2'd1);
        send_point(coord_t'(12345), coord_t'(-54321), coord_t'(777), 1'b1);

        // Back to 3D with mixed signs.
        settle();
        write_dimensions(DIM_3D);
        send_point(coord_t'(256), coord_t'(-256), coord_t'(1), 1'b0);
        send_point(coord_t'(-1000), coord_t'(3000), coord_t'(-5), 1'b0);
        send_point(C_MAX, coord_t'(-1), coord_t'(2), 1'b0);
        send_point(coord_t'(-77), C_MIN, coord_t'(-9), 1'b1);

        // Random phases: a mode, then a few whole sets in it. The receiver
        // squeeze starts with the first phase, while points are still flowing.
        while (points_sent < RANDOM_TARGET) begin
            settle();
            write_dimensions(pick_mode());
            squeeze_armed <= 1'b1;
            repeat ($urandom_range(2, 6)) begin
                run_random_set(pick_set_size(), point_style_e'($urandom_range(0, 2)));
            end
        end

        // Drain: all results in, then a few more cycles for any stray one.
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (results_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
